/* rtl/ucli_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ucli_pkg
// Shared constants and types of the command line interpreter.
// ----------------------------------------------------------------------------
package ucli_pkg;

    localparam int FIELD_COUNT = 5;
    localparam int FIELD_CHARS = 4;
    localparam int LINE_LIMIT  = 30;
    localparam int STORE_SIZE  = FIELD_COUNT * FIELD_CHARS;
    localparam int FIDX_W      = $clog2(FIELD_COUNT);
    localparam int CCNT_W      = $clog2(FIELD_CHARS + 1);
    localparam int LPOS_W      = $clog2(LINE_LIMIT + 1);
    localparam int QDEPTH      = 2;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_BANG = 8'h21;

    typedef enum logic [2:0] {
        ST_LED      = 3'd0,
        ST_MEMW     = 3'd1,
        ST_MEMR     = 3'd2,
        ST_ADC      = 3'd3,
        ST_VER      = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_BIG      = 3'd6,
        ST_PARSE    = 3'd7
    } status_t;

    typedef logic [STORE_SIZE-1:0][7:0] line_t;

    // one finished line handed from the front to the back
    typedef struct packed {
        logic  parse_failed;
        line_t fields;
    } line_item_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  led_pin;
        logic        led_level;
        logic [7:0]  mem_value;
    } result_t;

    // positions outside the field grid read as zero
    function automatic logic [7:0] ch(line_t s, int f, int c);
        if (f >= FIELD_COUNT || c >= FIELD_CHARS)
            return 8'h00;
        return s[f * FIELD_CHARS + c];
    endfunction

    function automatic logic is_digit(logic [7:0] d);
        return (d >= 8'h30) && (d <= 8'h39);
    endfunction

endpackage
`default_nettype wire

/* rtl/ucli_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ucli_front
// Splits incoming bytes into fields; emits one line item per line feed.
// ----------------------------------------------------------------------------
module ucli_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 byte_valid,
    input  wire logic [7:0]           rx_byte,
    output logic                      byte_ready,
    output logic                      line_valid,
    output ucli_pkg::line_item_t      line_item,
    input  wire logic                 line_ready
);

    ucli_pkg::line_t                    store_reg,   store_next;
    logic [ucli_pkg::FIDX_W-1:0]        fidx_reg,    fidx_next;
    logic [ucli_pkg::CCNT_W-1:0]        ccnt_reg,    ccnt_next;
    logic [ucli_pkg::LPOS_W-1:0]        lpos_reg,    lpos_next;
    logic                               pfail_reg,   pfail_next;
    logic                               is_lf;
    logic                               take;

    assign is_lf      = (rx_byte == ucli_pkg::CH_LF);
    // only a line feed needs room downstream
    assign byte_ready = !is_lf || line_ready;
    assign take       = byte_valid && byte_ready;
    assign line_valid = byte_valid && is_lf;
    assign line_item.parse_failed = pfail_reg;
    assign line_item.fields       = store_reg;

    always_comb
    begin
        store_next = store_reg;
        fidx_next  = fidx_reg;
        ccnt_next  = ccnt_reg;
        lpos_next  = lpos_reg;
        pfail_next = pfail_reg;
        if (take && rx_byte != 8'h00 && rx_byte != ucli_pkg::CH_CR)
        begin
            if (is_lf)
            begin
                store_next = '0;
                fidx_next  = '0;
                ccnt_next  = '0;
                lpos_next  = '0;
                pfail_next = 1'b0;
            end
            else if (!pfail_reg)
            begin
                if (lpos_reg >= ucli_pkg::LPOS_W'(ucli_pkg::LINE_LIMIT))
                    pfail_next = 1'b1;
                else
                begin
                    lpos_next = lpos_reg + 1'b1;
                    if (rx_byte == ucli_pkg::CH_SP)
                    begin
                        if (fidx_reg == ucli_pkg::FIDX_W'(ucli_pkg::FIELD_COUNT - 1))
                            pfail_next = 1'b1;
                        else
                            fidx_next = fidx_reg + 1'b1;
                        ccnt_next = '0;
                    end
                    else if (ccnt_reg < ucli_pkg::CCNT_W'(ucli_pkg::FIELD_CHARS))
                    begin
                        store_next[32'(fidx_reg) * ucli_pkg::FIELD_CHARS
                                   + 32'(ccnt_reg)] = rx_byte;
                        ccnt_next = ccnt_reg + 1'b1;
                    end
                    else
                        pfail_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            fidx_reg  <= '0;
            ccnt_reg  <= '0;
            lpos_reg  <= '0;
            pfail_reg <= 1'b0;
        end
        else
        begin
            store_reg <= store_next;
            fidx_reg  <= fidx_next;
            ccnt_reg  <= ccnt_next;
            lpos_reg  <= lpos_next;
            pfail_reg <= pfail_next;
        end
    end

`ifndef ASSERT_OFF
    a_fidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fidx_reg) < ucli_pkg::FIELD_COUNT)
        else $error("field index out of range");
    a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_lf |=> lpos_reg == '0 && !pfail_reg)
        else $error("line state not cleared");
    a_ccnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ccnt_reg) <= ucli_pkg::FIELD_CHARS)
        else $error("char count out of range");
`endif

endmodule
`default_nettype wire

/* rtl/ucli_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ucli_queue
// Two-entry queue of finished lines between the front and the back.
// ----------------------------------------------------------------------------
module ucli_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_valid,
    input  wire ucli_pkg::line_item_t wr_item,
    output logic                      wr_ready,
    output logic                      rd_valid,
    output ucli_pkg::line_item_t      rd_item,
    input  wire logic                 rd_ready
);

    ucli_pkg::line_item_t                  mem_reg [ucli_pkg::QDEPTH];
    logic [$clog2(ucli_pkg::QDEPTH)-1:0]   wp_reg, rp_reg;
    logic [$clog2(ucli_pkg::QDEPTH+1)-1:0] cnt_reg;
    logic                                  wr, rd;

    assign wr_ready = (32'(cnt_reg) < ucli_pkg::QDEPTH);
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg) <= ucli_pkg::QDEPTH)
        else $error("queue count overflow");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 || 32'(cnt_reg) == ucli_pkg::QDEPTH |-> wp_reg == rp_reg)
        else $error("queue pointers inconsistent");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr && !rd |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count did not advance");
`endif

endmodule
`default_nettype wire

/* rtl/ucli_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ucli_back
// Runs one line as a command and registers its status result.
// ----------------------------------------------------------------------------
module ucli_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 line_valid,
    input  wire ucli_pkg::line_item_t line_item,
    output logic                      line_ready,
    output logic                      res_valid,
    output ucli_pkg::result_t         res,
    input  wire logic                 res_ready
);

    ucli_pkg::line_t   prev_reg, prev_next;
    logic              pvalid_reg, pvalid_next;
    logic [7:0]        mem_reg, mem_next;
    logic              rvalid_reg;
    ucli_pkg::result_t res_reg, res_next;
    ucli_pkg::line_t   s;
    logic              repeat_cmd, use_cmd, known;
    logic [7:0]        c0, c1, c2, d0, d1, d2;
    logic [9:0]        value;
    logic              take;

    assign line_ready = !rvalid_reg || res_ready;
    assign take       = line_valid && line_ready;
    assign res_valid  = rvalid_reg;
    assign res        = res_reg;

    always_comb
    begin
        prev_next   = prev_reg;
        pvalid_next = pvalid_reg;
        mem_next    = mem_reg;
        res_next    = '0;
        res_next.status = ucli_pkg::ST_NOTFOUND;
        repeat_cmd  = (ucli_pkg::ch(line_item.fields, 0, 0) == ucli_pkg::CH_BANG) &&
                      (ucli_pkg::ch(line_item.fields, 0, 1) == ucli_pkg::CH_BANG);
        s           = repeat_cmd ? prev_reg : line_item.fields;
        use_cmd     = !line_item.parse_failed && (!repeat_cmd || pvalid_reg);
        c0 = ucli_pkg::ch(s, 0, 0);
        c1 = ucli_pkg::ch(s, 0, 1);
        c2 = ucli_pkg::ch(s, 0, 2);
        d0 = ucli_pkg::ch(s, 1, 0);
        d1 = ucli_pkg::ch(s, 1, 1);
        d2 = ucli_pkg::ch(s, 1, 2);
        known = 1'b1;
        // digits are read from the left, the first one most significant; up to three form the value
        value = '0;
        if (d1 == 8'h00)
            value = (d2 != 8'h00) ? 10'(d0 - 8'h30) * 10'd10 : 10'(d0 - 8'h30);
        else if (d2 == 8'h00)
            value = 10'(d0 - 8'h30) * 10'd10 + 10'(d1 - 8'h30);
        else
            value = 10'(d0 - 8'h30) * 10'd100 + 10'(d1 - 8'h30) * 10'd10
                    + 10'(d2 - 8'h30);

        if (c0 == "L" && c1 == "D")
        begin
            if (d0 == "0")
                res_next.led_pin = 4'd0;
            else if (d0 == "7")
                res_next.led_pin = 4'd7;
            else if (d0 == "1" && d1 == "4")
                res_next.led_pin = 4'd14;
            else
                res_next.status = ucli_pkg::ST_NOTFOUND;
            if (d0 == "0" || d0 == "7" || (d0 == "1" && d1 == "4"))
            begin
                if (ucli_pkg::ch(s, 2, 0) == "O" && ucli_pkg::ch(s, 2, 1) == "N")
                begin
                    res_next.status    = ucli_pkg::ST_LED;
                    res_next.led_level = 1'b1;
                end
                else if (ucli_pkg::ch(s, 2, 0) == "O" && ucli_pkg::ch(s, 2, 1) == "F"
                         && ucli_pkg::ch(s, 2, 2) == "F")
                    res_next.status = ucli_pkg::ST_LED;
            end
        end
        else if (c0 == "M" && c1 == "W")
        begin
            if (ucli_pkg::ch(s, 1, 3) != 8'h00 || d0 == 8'h00)
                res_next.status = ucli_pkg::ST_NOTFOUND;
            else if (!ucli_pkg::is_digit(d0) ||
                     (d1 != 8'h00 && !ucli_pkg::is_digit(d1)) ||
                     (d2 != 8'h00 && !ucli_pkg::is_digit(d2)))
                res_next.status = ucli_pkg::ST_NOTFOUND;
            else if (value >= 10'd256)
                res_next.status = ucli_pkg::ST_BIG;
            else
                res_next.status = ucli_pkg::ST_MEMW;
        end
        else if (c0 == "M" && c1 == "R")
            res_next.status = ucli_pkg::ST_MEMR;
        else if (c0 == "A" && c1 == "D" && c2 == "C")
            res_next.status = ucli_pkg::ST_ADC;
        else if (c0 == "V" && c1 == "E" && c2 == "R")
            res_next.status = ucli_pkg::ST_VER;
        else
            known = 1'b0;

        if (!use_cmd)
        begin
            res_next = '0;
            res_next.status = line_item.parse_failed ? ucli_pkg::ST_PARSE
                                                     : ucli_pkg::ST_NOTFOUND;
        end
        else if (take)
        begin
            if (res_next.status == ucli_pkg::ST_MEMW)
                mem_next = value[7:0];
            if (known)
            begin
                prev_next   = s;
                pvalid_next = 1'b1;
            end
        end
        if (res_next.status == ucli_pkg::ST_MEMW)
            res_next.mem_value = value[7:0];
        else if (res_next.status == ucli_pkg::ST_MEMR)
            res_next.mem_value = mem_reg;
        if (res_next.status != ucli_pkg::ST_LED)
        begin
            res_next.led_pin   = '0;
            res_next.led_level = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            pvalid_reg <= 1'b0;
            mem_reg    <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            prev_reg   <= prev_next;
            pvalid_reg <= pvalid_next;
            mem_reg    <= mem_next;
            if (take)
                rvalid_reg <= 1'b1;
            else if (res_ready)
                rvalid_reg <= 1'b0;
        end
    end

`ifndef ASSERT_OFF
    a_led_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg && res_reg.status != ucli_pkg::ST_LED |->
        res_reg.led_pin == '0 && !res_reg.led_level)
        else $error("led fields set without led status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rvalid_reg && !res_ready |=> rvalid_reg && $stable(res_reg))
        else $error("stalled result changed");
    a_mem_only_w: assert property (@(posedge clk) disable iff (!rst_n)
        mem_reg != $past(mem_reg) |-> $past(take))
        else $error("memory byte changed without a command");
`endif

endmodule
`default_nettype wire

/* rtl/uart_command_line_interpreter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// uart_command_line_interpreter
// Line parser and command executor for received text bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive rx_byte and raise push while full is low; one byte is
//   taken per cycle. Zero and carriage return bytes are dropped, other
//   characters build fields, a line feed runs the line as a command.
//   Output queue: while empty is low, status/led_pin/led_level/mem_value hold
//   the oldest result; raise pop to take it. One result per line feed.
// Result path: a line feed's line item is written into the line queue, then
//   the back end runs it and lands its result in the result register, where
//   empty goes low and the result can be popped.
// Throughput: one byte per cycle; a line feed is held off (full high) only
//   when the two-entry line queue is full, which follows a stalled result
//   side. Plain characters are never held off.
// Reset: clears the field store, line state, last command and memory byte;
//   both queues come up empty.
// ----------------------------------------------------------------------------
module uart_command_line_interpreter (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] rx_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [2:0]      status,
    output logic [3:0]      led_pin,
    output logic            led_level,
    output logic [7:0]      mem_value
);

    logic                 f_valid, f_ready, q_valid, q_ready, byte_ready, r_valid;
    ucli_pkg::line_item_t f_item, q_item;
    ucli_pkg::result_t    r;

    ucli_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (push),
        .rx_byte    (rx_byte),
        .byte_ready (byte_ready),
        .line_valid (f_valid),
        .line_item  (f_item),
        .line_ready (f_ready)
    );

    ucli_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_item  (f_item),
        .wr_ready (f_ready),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .rd_ready (q_ready)
    );

    ucli_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_valid (q_valid),
        .line_item  (q_item),
        .line_ready (q_ready),
        .res_valid  (r_valid),
        .res        (r),
        .res_ready  (pop)
    );

    assign full      = !byte_ready;
    assign empty     = !r_valid;
    assign status    = r.status;
    assign led_pin   = r.led_pin;
    assign led_level = r.led_level;
    assign mem_value = r.mem_value;

endmodule
`default_nettype wire
